FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons follows whenever ante holds
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/prtf_pkg.sv
// ----------------------------------------------------------------------------
// prtf_pkg
// Types, constants and coefficient tables of the planar rigid frame transform.
// ----------------------------------------------------------------------------
package prtf_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int HEAD_W  = 17;
    localparam int TRIG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Angle handling, all in centidegrees
    localparam int FULL_TURN = 36000;
    localparam int QUARTER   = 9000;
    localparam int EIGHTH    = 4500;

    // pi / 18000 in Q40
    localparam logic [27:0] RAD_Q40 = 28'd191900981;

    // Q30 fixed point for the series evaluation
    localparam int Q30_W = 30;
    localparam logic [Q30_W:0] Q30_ONE = 31'h4000_0000;

    // Series depth and cell latency
    localparam int SIN_TERMS = 4;
    localparam int COS_TERMS = 5;
    localparam int CELL_LAT  = 3;

    // Heading pipeline: reduce, fold, angle scale, square, cos chain, final
    localparam int SETTLE_CYCLES = 4 + CELL_LAT * COS_TERMS + 1 + 2;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_HEADING  = 2'd2
    } cfg_reg_t;

    // Data handed from one series cell to the next
    typedef struct packed {
        logic [Q30_W-1:0] x;
        logic [Q30_W-1:0] x2;
        logic [Q30_W:0]   t;
    } trig_lane_t;

    // Horner divisors of the sine series, innermost first
    function automatic int sin_div(input int idx);
        int d;
        case (idx)
            0:       d = 72;
            1:       d = 42;
            2:       d = 20;
            default: d = 6;
        endcase
        return d;
    endfunction

    // Horner divisors of the cosine series, innermost first
    function automatic int cos_div(input int idx);
        int d;
        case (idx)
            0:       d = 90;
            1:       d = 56;
            2:       d = 30;
            3:       d = 12;
            default: d = 2;
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/prtf_cell.sv
// ----------------------------------------------------------------------------
// prtf_cell
// One Horner step of a Taylor series in Q30: t_out = 1 - floor((x2*t)/d).
// Three register stages; x and x2 ride along to the next cell.
// ----------------------------------------------------------------------------
module prtf_cell
    import prtf_pkg::*;
#(
    parameter int DIVISOR = 2
)
(
    input  logic       clk,
    input  trig_lane_t lane_in,
    output trig_lane_t lane_out
);

    // Reciprocal for the constant divide, worked out at elaboration
    localparam logic [Q30_W-1:0] RECIP = Q30_W'((32'd1 << Q30_W) / DIVISOR);
    localparam logic [Q30_W:0]   DIV_C = (Q30_W+1)'(DIVISOR);

    logic [Q30_W-1:0]   x_s1_reg, x2_s1_reg, p_s1_reg;
    logic [Q30_W-1:0]   x_s2_reg, x2_s2_reg, p_s2_reg, q0_s2_reg;
    trig_lane_t         lane_reg;

    logic [2*Q30_W:0]   prod_sq;
    logic [2*Q30_W-1:0] prod_rc;
    logic [Q30_W:0]     rem;
    logic [Q30_W:0]     quot;
    trig_lane_t         lane_next;

    // Scale the running term by x squared
    assign prod_sq = (2*Q30_W+1)'(lane_in.x2) * (2*Q30_W+1)'(lane_in.t);

    always_ff @(posedge clk)
    begin
        x_s1_reg  <= lane_in.x;
        x2_s1_reg <= lane_in.x2;
        p_s1_reg  <= prod_sq[2*Q30_W-1:Q30_W];
    end

    // Estimate the quotient, low by at most one
    assign prod_rc = (2*Q30_W)'(p_s1_reg) * (2*Q30_W)'(RECIP);

    always_ff @(posedge clk)
    begin
        x_s2_reg  <= x_s1_reg;
        x2_s2_reg <= x2_s1_reg;
        p_s2_reg  <= p_s1_reg;
        q0_s2_reg <= prod_rc[2*Q30_W-1:Q30_W];
    end

    // Correct the quotient and subtract from one
    always_comb
    begin
        rem  = (Q30_W+1)'(p_s2_reg) - (Q30_W+1)'(q0_s2_reg) * DIV_C;
        quot = (rem >= DIV_C) ? (Q30_W+1)'(q0_s2_reg) + 1'b1 : (Q30_W+1)'(q0_s2_reg);
        lane_next.x  = x_s2_reg;
        lane_next.x2 = x2_s2_reg;
        lane_next.t  = Q30_ONE - quot;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

FILE: hdl/prtf_sincos.sv
// ----------------------------------------------------------------------------
// prtf_sincos
// Sine and cosine of the configured heading in Q1.15. Reduces the angle to
// one octant, scales it to radians and runs two chains of series cells.
// Holds busy while a new heading works its way through.
// ----------------------------------------------------------------------------
module prtf_sincos
    import prtf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     heading_wr,
    input  logic signed [HEAD_W-1:0] heading,
    output logic signed [TRIG_W-1:0] sin_q,
    output logic signed [TRIG_W-1:0] cos_q,
    output logic                     busy
);

    logic [SETTLE_W-1:0]   settle_reg, settle_next;
    logic [15:0]           amod_reg, amod_next;
    logic [12:0]           ang_reg, ang_next;
    logic [1:0]            quad_reg, quad_next;
    logic                  swap_reg, swap_next;
    logic [Q30_W-1:0]      x_reg, x_next;
    logic [Q30_W-1:0]      xs_reg, x2_reg, x2_next;
    logic [Q30_W:0]        sin_t30_reg;
    logic signed [TRIG_W-1:0] sin_reg, sin_next, cos_reg, cos_next;

    logic signed [HEAD_W:0] a0, a1, a2, a3;
    logic [13:0]           rmd;
    logic [40:0]           ang_prod;
    logic [2*Q30_W-1:0]    sq_prod;
    logic [2*Q30_W:0]      sin_prod;
    logic [14:0]           s_oct, c_oct, s0, c0;

    trig_lane_t sin_lane [SIN_TERMS+1];
    trig_lane_t cos_lane [COS_TERMS+1];

    // Round a Q30 value to Q1.15 and clamp below one
    function automatic logic [14:0] q30_to_q15(input logic [Q30_W:0] v);
        logic [Q30_W+1:0] r;
        r = (Q30_W+2)'(v) + (Q30_W+2)'(16384);
        r = r >> 15;
        return (r > (Q30_W+2)'(32767)) ? 15'h7fff : r[14:0];
    endfunction

    // Count down the settle time after a heading write
    always_comb
    begin
        if (heading_wr)
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        else
            settle_reg <= settle_next;
    end

    assign busy = (settle_reg != '0);

    // Wrap the heading into one full turn
    always_comb
    begin
        a0 = (HEAD_W+1)'(heading);
        a1 = (a0 >= (HEAD_W+1)'(FULL_TURN)) ? a0 - (HEAD_W+1)'(FULL_TURN) : a0;
        a2 = (a1 < 0) ? a1 + (HEAD_W+1)'(FULL_TURN) : a1;
        a3 = (a2 < 0) ? a2 + (HEAD_W+1)'(FULL_TURN) : a2;
        amod_next = a3[15:0];
    end

    // Split into quadrant and octant angle
    always_comb
    begin
        if (amod_reg >= 16'(3 * QUARTER))
        begin
            quad_next = 2'd3;
            rmd = 14'(amod_reg - 16'(3 * QUARTER));
        end
        else if (amod_reg >= 16'(2 * QUARTER))
        begin
            quad_next = 2'd2;
            rmd = 14'(amod_reg - 16'(2 * QUARTER));
        end
        else if (amod_reg >= 16'(QUARTER))
        begin
            quad_next = 2'd1;
            rmd = 14'(amod_reg - 16'(QUARTER));
        end
        else
        begin
            quad_next = 2'd0;
            rmd = amod_reg[13:0];
        end
        swap_next = (rmd > 14'(EIGHTH));
        ang_next  = swap_next ? 13'(14'(QUARTER) - rmd) : rmd[12:0];
    end

    // Scale to radians in Q30, then square
    assign ang_prod = 41'(ang_reg) * 41'(RAD_Q40) + 41'd512;
    assign x_next   = ang_prod[Q30_W+9:10];
    assign sq_prod  = (2*Q30_W)'(x_reg) * (2*Q30_W)'(x_reg);
    assign x2_next  = sq_prod[2*Q30_W-1:Q30_W];

    always_ff @(posedge clk)
    begin
        amod_reg <= amod_next;
        ang_reg  <= ang_next;
        quad_reg <= quad_next;
        swap_reg <= swap_next;
        x_reg    <= x_next;
        xs_reg   <= x_reg;
        x2_reg   <= x2_next;
    end

    // Sine and cosine series chains
    assign sin_lane[0] = '{x: xs_reg, x2: x2_reg, t: Q30_ONE};
    assign cos_lane[0] = '{x: xs_reg, x2: x2_reg, t: Q30_ONE};

    for (genvar i = 0; i < SIN_TERMS; i++)
    begin : g_sin
        prtf_cell #(.DIVISOR(sin_div(i))) u_cell (
            .clk      (clk),
            .lane_in  (sin_lane[i]),
            .lane_out (sin_lane[i+1])
        );
    end

    for (genvar i = 0; i < COS_TERMS; i++)
    begin : g_cos
        prtf_cell #(.DIVISOR(cos_div(i))) u_cell (
            .clk      (clk),
            .lane_in  (cos_lane[i]),
            .lane_out (cos_lane[i+1])
        );
    end

    // Multiply the sine series by x
    assign sin_prod = (2*Q30_W+1)'(sin_lane[SIN_TERMS].x) * (2*Q30_W+1)'(sin_lane[SIN_TERMS].t);

    always_ff @(posedge clk)
    begin
        sin_t30_reg <= sin_prod[2*Q30_W:Q30_W];
    end

    // Unfold octant and quadrant; quadrant and swap hold steady once settled
    always_comb
    begin
        s_oct = q30_to_q15(sin_t30_reg);
        c_oct = q30_to_q15(cos_lane[COS_TERMS].t);
        s0 = swap_reg ? c_oct : s_oct;
        c0 = swap_reg ? s_oct : c_oct;
        case (quad_reg)
            2'd0:
            begin
                cos_next = TRIG_W'(c0);
                sin_next = TRIG_W'(s0);
            end
            2'd1:
            begin
                cos_next = -TRIG_W'(s0);
                sin_next = TRIG_W'(c0);
            end
            2'd2:
            begin
                cos_next = -TRIG_W'(c0);
                sin_next = -TRIG_W'(s0);
            end
            default:
            begin
                cos_next = TRIG_W'(s0);
                sin_next = -TRIG_W'(c0);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

FILE: hdl/planar_rigid_frame_transform.sv
// ----------------------------------------------------------------------------
// planar_rigid_frame_transform
// Rotates and translates 2D points between a map frame and a local frame
// whose origin and heading are set through the configuration port.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------
//  input     start && !busy         mode, point_x, point_y
//  result    done (one cycle)       out_x, out_y, overflow
//  config    cfg_we                 cfg_addr, cfg_wdata
//
//  A point is taken every cycle while busy is low; its result shows on done
//  at the end of the five stage point pipeline (operands, products, sums,
//  rounding, output). After reset and after each heading write, busy stays
//  high while the heading runs through the series cells.
//  Results cannot be held off; done marks each for a single cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_rigid_frame_transform
    import prtf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output logic                      done,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic                      overflow,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [COORD_W-1:0]        cfg_wdata
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = TRIG_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - 15;
    localparam int FIN_W  = RND_W + 1;
    localparam logic signed [FIN_W-1:0] SAT_MAX = FIN_W'(32'sh7fff_ffff);
    localparam logic signed [FIN_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic                      heading_wr;
    logic signed [TRIG_W-1:0]  sin_q, cos_q;
    logic                      accept;

    logic [3:0]                vld_reg, vld_next;
    logic                      done_reg;
    logic [3:0]                mode_reg;

    logic signed [DIFF_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic signed [PROD_W-1:0]  p_ca_reg, p_sb_reg, p_cb_reg, p_sa_reg;
    logic signed [SUM_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SUM_W-1:0]   rnd_x, rnd_y;
    logic signed [RND_W-1:0]   rx_reg, ry_reg;
    logic signed [FIN_W-1:0]   fx, fy;
    logic signed [COORD_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                      ovf_reg, ovf_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            heading_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_HEADING:  heading_reg  <= cfg_wdata[HEAD_W-1:0];
                default:      ;
            endcase
        end
    end

    assign heading_wr = cfg_we && (cfg_addr == REG_HEADING);

    prtf_sincos u_sincos (
        .clk        (clk),
        .rst_n      (rst_n),
        .heading_wr (heading_wr),
        .heading    (heading_reg),
        .sin_q      (sin_q),
        .cos_q      (cos_q),
        .busy       (busy)
    );

    assign accept = start && !busy;

    // Shift each accept into the valid bits
    assign vld_next = {vld_reg[2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[3];
        end
    end

    // Form the operands: difference to origin or plain point
    always_comb
    begin
        if (mode)
        begin
            a_next = DIFF_W'(point_x);
            b_next = DIFF_W'(point_y);
        end
        else
        begin
            a_next = DIFF_W'(point_x) - DIFF_W'(origin_x_reg);
            b_next = DIFF_W'(point_y) - DIFF_W'(origin_y_reg);
        end
    end

    // Combine products by direction of the rotation
    always_comb
    begin
        if (mode_reg[1])
        begin
            sx_next = SUM_W'(p_ca_reg) - SUM_W'(p_sb_reg);
            sy_next = SUM_W'(p_sa_reg) + SUM_W'(p_cb_reg);
        end
        else
        begin
            sx_next = SUM_W'(p_ca_reg) + SUM_W'(p_sb_reg);
            sy_next = SUM_W'(p_cb_reg) - SUM_W'(p_sa_reg);
        end
    end

    // Round to nearest, ties up
    assign rnd_x = sx_reg + SUM_W'(16384);
    assign rnd_y = sy_reg + SUM_W'(16384);

    // Add origin back for local to map, then saturate
    always_comb
    begin
        fx = FIN_W'(rx_reg);
        fy = FIN_W'(ry_reg);
        if (mode_reg[3])
        begin
            fx = fx + FIN_W'(origin_x_reg);
            fy = fy + FIN_W'(origin_y_reg);
        end
        ovf_next = 1'b0;
        if (fx > SAT_MAX)
        begin
            out_x_next = COORD_W'(SAT_MAX);
            ovf_next   = 1'b1;
        end
        else if (fx < SAT_MIN)
        begin
            out_x_next = COORD_W'(SAT_MIN);
            ovf_next   = 1'b1;
        end
        else
            out_x_next = COORD_W'(fx);
        if (fy > SAT_MAX)
        begin
            out_y_next = COORD_W'(SAT_MAX);
            ovf_next   = 1'b1;
        end
        else if (fy < SAT_MIN)
        begin
            out_y_next = COORD_W'(SAT_MIN);
            ovf_next   = 1'b1;
        end
        else
            out_y_next = COORD_W'(fy);
    end

    // Point pipeline registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= {mode_reg[2:0], mode};
        a_reg     <= a_next;
        b_reg     <= b_next;
        p_ca_reg  <= PROD_W'(cos_q) * PROD_W'(a_reg);
        p_sb_reg  <= PROD_W'(sin_q) * PROD_W'(b_reg);
        p_cb_reg  <= PROD_W'(cos_q) * PROD_W'(b_reg);
        p_sa_reg  <= PROD_W'(sin_q) * PROD_W'(a_reg);
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        rx_reg    <= rnd_x[SUM_W-1:15];
        ry_reg    <= rnd_y[SUM_W-1:15];
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        ovf_reg   <= ovf_next;
    end

    assign done     = done_reg;
    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign overflow = ovf_reg;

    // Every accepted transaction comes out on done
    `ASSERT_IMPLIES(a_result_latency, start && !busy, ##5 done, "result missing after accept")
    // No result without a matching transaction
    `ASSERT_IMPLIES(a_no_spurious, done, $past(start && !busy, 5), "result without accept")
    // Busy rises only from a heading write
    `ASSERT_IMPLIES(a_busy_cause, $rose(busy), $past(cfg_we && cfg_addr == REG_HEADING),
                    "busy without heading write")
    // A flagged result sits on a rail
    `ASSERT_IMPLIES(a_ovf_rail, done && overflow,
                    out_x == 32'sh7fff_ffff || out_x == 32'sh8000_0000 ||
                    out_y == 32'sh7fff_ffff || out_y == 32'sh8000_0000,
                    "overflow without saturated output")

endmodule
